/* design/erbg_pkg.sv */
// erbg_pkg: types, fixed-point constants and stage structs for the echo
// ranging bar graph unit; used by every module in design/, depends on nothing

package erbg_pkg;

    // edge kind carried in req_type
    typedef enum logic {
        EDGE_RISE = 1'b0,
        EDGE_FALL = 1'b1
    } edge_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] timestamp_us;
    } erbg_in_t;

    typedef struct packed {
        logic [15:0] distance_centi;
        logic [7:0]  progress_percent;
        logic [4:0]  leds_lit;
        logic [15:0] bar_mask;
    } erbg_out_t;

    // pulse stage to scale stage
    typedef struct packed {
        logic        valid;
        logic [15:0] distance;
    } erbg_dist_t;

    // scale stage to bar stage
    typedef struct packed {
        logic        valid;
        logic [15:0] distance;
        logic [7:0]  progress;
    } erbg_prog_t;

    localparam int LED_COUNT_DEFAULT = 16;

    // distance = floor(width * 343 / 200), exact for width below the saturation point
    localparam logic [23:0] DIST_RECIP   = 24'd14386463;
    localparam int          DIST_SHIFT   = 23;
    localparam logic [31:0] WIDTH_SAT    = 32'd38214;
    localparam logic [15:0] DIST_MAX     = 16'hFFFF;

    localparam logic [15:0] MIN_DIST_RESET = 16'd500;

    // progress = floor(distance / 10), capped
    localparam logic [15:0] TENTH_RECIP   = 16'd52429;
    localparam int          TENTH_SHIFT   = 19;
    localparam logic [15:0] PROG_SAT_DIST = 16'd2010;
    localparam logic [7:0]  PROGRESS_CAP  = 8'd200;

    // leds = floor(progress * LED_COUNT / 200)
    localparam int LED_RECIP = 5243;
    localparam int LED_SHIFT = 20;

endpackage

/* design/erbg_pulse.sv */
// erbg_pulse: edge intake, pulse start state and width-to-distance stage
// depends on erbg_pkg

module erbg_pulse
    import erbg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  erbg_in_t   s_data,
    input  logic       ready_dn,
    output erbg_dist_t dist_o
);

    logic        start_seen_reg;
    logic [31:0] start_time_reg;
    logic        valid_reg;
    logic [15:0] distance_reg;

    logic        accept;
    logic        is_rise;
    logic [31:0] width;
    logic        sat;
    logic [39:0] dist_prod;
    logic [15:0] distance_next;

    assign s_ready = !valid_reg || ready_dn;
    assign accept  = s_valid && s_ready;
    assign is_rise = (s_data.req_type == EDGE_RISE);

    // width wraps modulo 2^32
    assign width     = s_data.timestamp_us - start_time_reg;
    assign sat       = (width >= WIDTH_SAT);
    assign dist_prod = 40'(width[15:0]) * 40'(DIST_RECIP);
    assign distance_next = sat ? DIST_MAX : dist_prod[DIST_SHIFT +: 16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seen_reg <= 1'b0;
            start_time_reg <= 32'd0;
            valid_reg      <= 1'b0;
        end else begin
            if (accept && is_rise) begin
                start_seen_reg <= 1'b1;
                start_time_reg <= s_data.timestamp_us;
            end
            // a falling edge before any start gives nothing
            if (s_ready) begin
                valid_reg <= accept && !is_rise && start_seen_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            distance_reg <= distance_next;
        end
    end

    assign dist_o.valid    = valid_reg;
    assign dist_o.distance = distance_reg;

endmodule

/* design/erbg_scale.sv */
// erbg_scale: minimum distance register, near-range blanking and progress stage
// depends on erbg_pkg

module erbg_scale
    import erbg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  erbg_dist_t  dist_i,
    output logic        ready_up,
    input  logic        ready_dn,
    output erbg_prog_t  prog_o
);

    logic [15:0] min_dist_reg;
    logic        valid_reg;
    logic [15:0] distance_reg;
    logic [7:0]  progress_reg;

    logic [15:0] dist_m;
    logic [26:0] tenth_prod;
    logic [7:0]  progress_next;

    assign ready_up = !valid_reg || ready_dn;

    assign dist_m        = (dist_i.distance <= min_dist_reg) ? 16'd0 : dist_i.distance;
    assign tenth_prod    = 27'(dist_m[10:0]) * 27'(TENTH_RECIP);
    assign progress_next = (dist_m >= PROG_SAT_DIST) ? PROGRESS_CAP
                                                     : tenth_prod[TENTH_SHIFT +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= MIN_DIST_RESET;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_dist_reg <= cfg_wr_data;
            end
            if (ready_up) begin
                valid_reg <= dist_i.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_up && dist_i.valid) begin
            distance_reg <= dist_m;
            progress_reg <= progress_next;
        end
    end

    assign prog_o.valid    = valid_reg;
    assign prog_o.distance = distance_reg;
    assign prog_o.progress = progress_reg;

endmodule

/* design/erbg_bar.sv */
// erbg_bar: led count, bar mask and the result register
// depends on erbg_pkg

module erbg_bar
    import erbg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  erbg_prog_t prog_i,
    output logic       ready_up,
    output logic       m_valid,
    input  logic       m_ready,
    output erbg_out_t  m_data
);

    localparam int LedMul = LED_COUNT * LED_RECIP;
    localparam int MulW   = $clog2(LedMul + 1);
    localparam int ProdW  = MulW + 9;
    localparam int LedW   = $clog2(LED_COUNT + 1);

    logic             m_valid_reg;
    erbg_out_t        m_data_reg;

    logic [ProdW-1:0] led_prod;
    logic [LedW-1:0]  leds;
    logic [6:0]       leds7;
    logic [15:0]      mask;

    assign ready_up = !m_valid_reg || m_ready;

    assign led_prod = ProdW'(prog_i.progress) * ProdW'(LedMul);
    assign leds     = led_prod[LED_SHIFT +: LedW];
    assign leds7    = 7'(leds);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            mask[i] = (leds7 > 7'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_up) begin
            m_valid_reg <= prog_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_up && prog_i.valid) begin
            m_data_reg.distance_centi   <= prog_i.distance;
            m_data_reg.progress_percent <= prog_i.progress;
            m_data_reg.leds_lit         <= leds7[4:0];
            m_data_reg.bar_mask         <= mask;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/echo_range_bar_graph_unit.sv */
// echo_range_bar_graph_unit: top level, three register stages from echo edge to bar graph
// depends on erbg_pkg, erbg_pulse, erbg_scale, erbg_bar
//
// usage:
//   s_ channel takes echo edge events (rising or falling, with a microsecond
//   timestamp). a rising edge stores the pulse start; a falling edge after a
//   start yields one result on the m_ channel: distance in hundredths of a cm,
//   progress percent, lit led count and bar mask. other edges yield nothing.
//   cfg_wr_en/cfg_wr_data write the minimum distance (reset 500); distances at
//   or below it read as zero. write it only while the pipeline is empty.
// timing:
//   one transfer per cycle on s_ while m_ is taken every cycle. an input
//   transfer reaches m_ through one register after each of the three constant
//   multiplies (width to distance, distance to percent, percent to led count);
//   m_valid rises once the last of these registers is loaded.
// reset:
//   aresetn low clears the start state, all stage valids and restores the
//   minimum distance register.
// stall:
//   when m_ready is low the result holds; the stages fill behind it and
//   s_ready drops once all three are occupied.

module echo_range_bar_graph_unit
    import erbg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  erbg_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output erbg_out_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    erbg_dist_t dist_s;
    erbg_prog_t prog_s;
    logic       scale_ready;
    logic       bar_ready;

    erbg_pulse u_pulse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .ready_dn (scale_ready),
        .dist_o   (dist_s)
    );

    erbg_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .dist_i      (dist_s),
        .ready_up    (scale_ready),
        .ready_dn    (bar_ready),
        .prog_o      (prog_s)
    );

    erbg_bar #(
        .LED_COUNT (LED_COUNT)
    ) u_bar (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .prog_i   (prog_s),
        .ready_up (bar_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* design/erbg_checker.sv */
// erbg_checker: port-level assertions for echo_range_bar_graph_unit, bound to the top
// depends on erbg_pkg

module erbg_checker
    import erbg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input erbg_out_t   m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // after reset m_valid stays low until an input has passed the pulse, scale and bar registers
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result too soon after reset");

    // progress is the floored tenth of distance, capped
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.progress_percent <= PROGRESS_CAP) &&
            (32'(m_data.progress_percent) * 32'd10 <= 32'(m_data.distance_centi)) &&
            ((m_data.progress_percent == PROGRESS_CAP) ||
             (32'(m_data.distance_centi) < 32'(m_data.progress_percent) * 32'd10 + 32'd10)))
        else $error("progress does not match distance");

    // bar mask is a solid run of leds_lit low bits
    a_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (LED_COUNT > 16) ||
            (($countones(m_data.bar_mask) == 32'(m_data.leds_lit)) &&
             ((m_data.bar_mask & (m_data.bar_mask + 16'd1)) == 16'd0)))
        else $error("bar mask does not match led count");

endmodule

bind echo_range_bar_graph_unit erbg_checker #(.LED_COUNT(LED_COUNT)) u_erbg_checker (.*);
